### hw/rtl/mrtu_pkg.sv
`default_nettype none

package mrtu_pkg;

  localparam int unsigned MIN_BODY_BYTES  = 3;
  localparam int unsigned MAX_PDU_BYTES   = 253;
  localparam int unsigned SAFE_BODY_LIMIT = 512;
  // body = PDU plus two CRC bytes
  localparam int unsigned MAX_BODY_BYTES  = MAX_PDU_BYTES + 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_RATE_LIMIT  = 3'd1;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd3;
  localparam logic [2:0] ST_ADDR_MISS   = 3'd4;
  localparam logic [2:0] ST_PDU_TOO_LONG = 3'd5;
  localparam logic [2:0] ST_CRC_ERR     = 3'd6;

  localparam logic [2:0] REG_GAP_TICKS   = 3'd0;
  localparam logic [2:0] REG_STATION     = 3'd1;
  localparam logic [2:0] REG_MASTER_MODE = 3'd2;
  localparam logic [2:0] REG_RATE_EN     = 3'd3;
  localparam logic [2:0] REG_MAX_FRAMES  = 3'd4;
  localparam logic [2:0] REG_WINDOW      = 3'd5;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] gap_ticks;
    logic [7:0]  station_address;
    logic        master_mode;
    logic        rate_limit_enable;
    logic [15:0] max_frames_per_window;
    logic [23:0] window_ticks;
  } mrtu_cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] window_elapsed;
    logic [15:0] window_count;
    logic [31:0] drop_total;
  } mrtu_verdict_t;

endpackage

`default_nettype wire

### hw/rtl/modbus_rtu_frame_checker_top.sv
`default_nettype none

// Modbus RTU receive frame checker. Each input item is either one received
// byte or one microsecond tick (tuser = 1). A frame closes once gap_ticks
// ticks pass with no byte, and that tick yields one result item carrying the
// verdict, address, function code, body length and the rate-limit drop count.
// One item is taken every clock unless a closing tick stalls. An item is held in
// the input register, where its state update and verdict are computed in one
// pass, and the result is registered in the output register as its closing
// tick leaves the input register. Bytes and ticks that close no frame keep
// flowing while a result waits; only a closing tick stalls until the output
// register is free or draining.
module modbus_rtu_frame_checker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] action: 0 byte, 1 tick
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [63:0] m_tdata,   // [2:0] status, [10:3] frame_address,
                                      // [18:11] function_code, [28:19] byte_count,
                                      // [60:29] dropped_frames, rest zero
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);
  import mrtu_pkg::*;

  mrtu_cfg_t cfg;

  logic       in_valid;
  logic       in_action;
  logic [7:0] in_byte;
  logic       adv;

  logic        in_frame, in_frame_next;
  logic [15:0] idle_count, idle_count_next;
  logic [9:0]  frame_bytes, frame_bytes_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] last_two_bytes, last_two_bytes_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_function, held_function_next;
  logic [23:0] window_elapsed, window_elapsed_next;
  logic [15:0] window_count, window_count_next;
  logic [31:0] drop_total, drop_total_next;

  logic [15:0] crc_src;
  logic [7:0]  crc_byte;
  logic [15:0] crc_new;
  logic [23:0] win_inc;
  logic [15:0] idle_inc;
  logic [15:0] gap_eff;
  logic        frame_end;
  mrtu_verdict_t verdict;

  // only a closing tick needs room in the output register
  assign adv      = in_valid && (!frame_end || !m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_ticks             <= 16'd1750;
      cfg.station_address       <= 8'd1;
      cfg.master_mode           <= 1'b0;
      cfg.rate_limit_enable     <= 1'b0;
      cfg.max_frames_per_window <= 16'd100;
      cfg.window_ticks          <= 24'd1000000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAP_TICKS:   cfg.gap_ticks             <= cfg_data[15:0];
        REG_STATION:     cfg.station_address       <= cfg_data[7:0];
        REG_MASTER_MODE: cfg.master_mode           <= cfg_data[0];
        REG_RATE_EN:     cfg.rate_limit_enable     <= cfg_data[0];
        REG_MAX_FRAMES:  cfg.max_frames_per_window <= cfg_data[15:0];
        REG_WINDOW:      cfg.window_ticks          <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser;
      in_byte   <= s_tdata;
    end
  end

  // Opening byte seeds from the init value; later, the byte two behind is
  // folded in so the trailing CRC pair stays out of the running sum.
  assign crc_src  = in_frame ? running_crc : CRC_INIT;
  assign crc_byte = in_frame ? last_two_bytes[15:8] : in_byte;

  mrtu_crc_byte u_crc (
    .crc_in  (crc_src),
    .data    (crc_byte),
    .crc_out (crc_new)
  );

  assign win_inc   = (window_elapsed != 24'hFFFFFF) ? window_elapsed + 24'd1 : window_elapsed;
  assign idle_inc  = (idle_count != 16'hFFFF) ? idle_count + 16'd1 : idle_count;
  assign gap_eff   = (cfg.gap_ticks == 16'd0) ? 16'd1 : cfg.gap_ticks;
  assign frame_end = (in_action == ACT_TICK) && in_frame && (idle_inc >= gap_eff);

  mrtu_judge u_judge (
    .cfg            (cfg),
    .frame_bytes    (frame_bytes),
    .held_address   (held_address),
    .running_crc    (running_crc),
    .last_two_bytes (last_two_bytes),
    .window_elapsed (win_inc),
    .window_count   (window_count),
    .drop_total     (drop_total),
    .verdict        (verdict)
  );

  always_comb begin
    in_frame_next       = in_frame;
    idle_count_next     = idle_count;
    frame_bytes_next    = frame_bytes;
    running_crc_next    = running_crc;
    last_two_bytes_next = last_two_bytes;
    held_address_next   = held_address;
    held_function_next  = held_function;
    window_elapsed_next = window_elapsed;
    window_count_next   = window_count;
    drop_total_next     = drop_total;
    if (in_action == ACT_BYTE) begin
      if (!in_frame) begin
        in_frame_next       = 1'b1;
        idle_count_next     = 16'd0;
        frame_bytes_next    = 10'd0;
        last_two_bytes_next = 16'd0;
        held_address_next   = in_byte;
        held_function_next  = 8'd0;
        running_crc_next    = crc_new;
      end else begin
        if (frame_bytes == 10'd0) begin
          held_function_next = in_byte;
        end
        if (frame_bytes >= 10'd2) begin
          running_crc_next = crc_new;
        end
        last_two_bytes_next = {last_two_bytes[7:0], in_byte};
        if (frame_bytes != 10'h3FF) begin
          frame_bytes_next = frame_bytes + 10'd1;
        end
        idle_count_next = 16'd0;
      end
    end else begin
      window_elapsed_next = win_inc;
      if (in_frame) begin
        idle_count_next = idle_inc;
      end
      if (frame_end) begin
        window_elapsed_next = verdict.window_elapsed;
        window_count_next   = verdict.window_count;
        drop_total_next     = verdict.drop_total;
        in_frame_next       = 1'b0;
        idle_count_next     = 16'd0;
        frame_bytes_next    = 10'd0;
        running_crc_next    = CRC_INIT;
        last_two_bytes_next = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      idle_count     <= 16'd0;
      frame_bytes    <= 10'd0;
      running_crc    <= CRC_INIT;
      last_two_bytes <= 16'd0;
      held_address   <= 8'd0;
      held_function  <= 8'd0;
      window_elapsed <= 24'd0;
      window_count   <= 16'd0;
      drop_total     <= 32'd0;
    end else if (adv) begin
      in_frame       <= in_frame_next;
      idle_count     <= idle_count_next;
      frame_bytes    <= frame_bytes_next;
      running_crc    <= running_crc_next;
      last_two_bytes <= last_two_bytes_next;
      held_address   <= held_address_next;
      held_function  <= held_function_next;
      window_elapsed <= window_elapsed_next;
      window_count   <= window_count_next;
      drop_total     <= drop_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && frame_end) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv && frame_end) begin
      m_tdata <= {3'd0, verdict.drop_total, frame_bytes, held_function, held_address,
                  verdict.status};
    end
  end

  // Outside a frame the body counters sit at their cleared values.
  assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (frame_bytes == 10'd0) && (last_two_bytes == 16'd0))
    else $error("body state not cleared outside a frame");

  // Drop count moves by at most one per item.
  assert property (@(posedge clk) disable iff (rst)
    (drop_total == $past(drop_total)) || (drop_total == $past(drop_total) + 32'd1))
    else $error("drop count jumped");

  // A new result only loads when the output slot is free or draining.
  assert property (@(posedge clk) disable iff (rst)
    (adv && frame_end) |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending item");

  // Status codes beyond CRC error are never produced.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_CRC_ERR))
    else $error("illegal status");

endmodule

`default_nettype wire

### hw/rtl/mrtu_crc_byte.sv
`default_nettype none

// One byte of Modbus CRC-16, LSB first.
module mrtu_crc_byte (
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);
  import mrtu_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

### hw/rtl/mrtu_judge.sv
`default_nettype none

module mrtu_judge (
  input  wire mrtu_pkg::mrtu_cfg_t cfg,
  input  wire logic [9:0]          frame_bytes,
  input  wire logic [7:0]          held_address,
  input  wire logic [15:0]         running_crc,
  input  wire logic [15:0]         last_two_bytes,
  input  wire logic [23:0]         window_elapsed,
  input  wire logic [15:0]         window_count,
  input  wire logic [31:0]         drop_total,
  output mrtu_pkg::mrtu_verdict_t  verdict
);
  import mrtu_pkg::*;

  logic        win_restart;
  logic [15:0] count_eff;
  logic        rate_hit;
  logic        addr_bad;
  logic [15:0] crc_expect;

  assign win_restart = cfg.rate_limit_enable && (window_elapsed >= cfg.window_ticks);
  assign count_eff   = win_restart ? 16'd0 : window_count;
  assign rate_hit    = cfg.rate_limit_enable && (count_eff >= cfg.max_frames_per_window);
  assign addr_bad    = (cfg.master_mode && (cfg.station_address == 8'd0)) ||
                       ((held_address != 8'd0) && (held_address != cfg.station_address));
  // low CRC byte goes out first on the wire
  assign crc_expect  = {running_crc[7:0], running_crc[15:8]};

  always_comb begin
    verdict.window_elapsed = win_restart ? 24'd0 : window_elapsed;
    verdict.drop_total     = rate_hit ? drop_total + 32'd1 : drop_total;
    verdict.window_count   = (cfg.rate_limit_enable && !rate_hit) ? count_eff + 16'd1
                                                                  : count_eff;
    if (rate_hit) begin
      verdict.status = ST_RATE_LIMIT;
    end else if (frame_bytes < 10'(MIN_BODY_BYTES)) begin
      verdict.status = ST_TOO_SHORT;
    end else if (frame_bytes > 10'(SAFE_BODY_LIMIT)) begin
      verdict.status = ST_TOO_LARGE;
    end else if (addr_bad) begin
      verdict.status = ST_ADDR_MISS;
    end else if (frame_bytes > 10'(MAX_BODY_BYTES)) begin
      verdict.status = ST_PDU_TOO_LONG;
    end else if (crc_expect != last_two_bytes) begin
      verdict.status = ST_CRC_ERR;
    end else begin
      verdict.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

import mrtu_pkg::*;

typedef struct {
  logic [2:0]  status;
  logic [7:0]  address;
  logic [7:0]  func_code;
  logic [9:0]  body_bytes;
  logic [31:0] drops;
} frame_verdict_t;

// Modbus CRC-16, one byte, LSB first
function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
  logic [15:0] c;
  c = crc ^ {8'h00, b};
  for (int k = 0; k < 8; k++) begin
    c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  end
  return c;
endfunction

class frame_verdict_tracker;
  mrtu_cfg_t      cfg;
  bit             in_frame;
  logic [15:0]    idle_cnt;
  logic [9:0]     body_cnt;
  logic [15:0]    crc;
  logic [15:0]    tail;
  logic [7:0]     address;
  logic [7:0]     func_code;
  logic [23:0]    win_elapsed;
  logic [15:0]    win_frames;
  logic [31:0]    drops;
  frame_verdict_t due[$];
  int unsigned    errors;

  function new();
    cfg.gap_ticks = 16'd1750;
    cfg.station_address = 8'd1;
    cfg.master_mode = 1'b0;
    cfg.rate_limit_enable = 1'b0;
    cfg.max_frames_per_window = 16'd100;
    cfg.window_ticks = 24'd1000000;
    close_frame();
    address = 8'h00;
    func_code = 8'h00;
    win_elapsed = 24'd0;
    win_frames = 16'd0;
    drops = 32'd0;
    errors = 0;
  endfunction

  function void close_frame();
    in_frame = 1'b0;
    idle_cnt = 16'd0;
    body_cnt = 10'd0;
    crc = CRC_INIT;
    tail = 16'h0000;
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      REG_GAP_TICKS:   cfg.gap_ticks = val[15:0];
      REG_STATION:     cfg.station_address = val[7:0];
      REG_MASTER_MODE: cfg.master_mode = val[0];
      REG_RATE_EN:     cfg.rate_limit_enable = val[0];
      REG_MAX_FRAMES:  cfg.max_frames_per_window = val[15:0];
      REG_WINDOW:      cfg.window_ticks = val;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return due.size();
  endfunction

  function logic [2:0] judge_frame();
    if (cfg.rate_limit_enable) begin
      if (win_elapsed >= cfg.window_ticks) begin
        win_elapsed = 24'd0;
        win_frames = 16'd0;
      end
      if (win_frames >= cfg.max_frames_per_window) begin
        drops = drops + 32'd1;
        return ST_RATE_LIMIT;
      end
      win_frames = win_frames + 16'd1;
    end
    if (body_cnt < MIN_BODY_BYTES) return ST_TOO_SHORT;
    if (body_cnt > SAFE_BODY_LIMIT) return ST_TOO_LARGE;
    if ((cfg.master_mode && cfg.station_address == 8'd0) ||
        (address != 8'd0 && address != cfg.station_address)) return ST_ADDR_MISS;
    if (body_cnt > MAX_BODY_BYTES) return ST_PDU_TOO_LONG;
    // CRC goes low byte first, so it sits byte-swapped in the tail
    if ({crc[7:0], crc[15:8]} != tail) return ST_CRC_ERR;
    return ST_OK;
  endfunction

  function void note_item(logic act, logic [7:0] b);
    logic [15:0]    gap;
    frame_verdict_t v;
    if (act == ACT_BYTE) begin
      if (!in_frame) begin
        close_frame();
        in_frame = 1'b1;
        address = b;
        func_code = 8'h00;
        crc = crc16_byte(CRC_INIT, b);
      end else begin
        if (body_cnt == 10'd0) func_code = b;
        // last two bytes are held back from the CRC until a newer byte shows up
        if (body_cnt >= 10'd2) crc = crc16_byte(crc, tail[15:8]);
        tail = {tail[7:0], b};
        if (body_cnt != 10'h3FF) body_cnt = body_cnt + 10'd1;
        idle_cnt = 16'd0;
      end
      return;
    end
    if (win_elapsed != 24'hFFFFFF) win_elapsed = win_elapsed + 24'd1;
    if (!in_frame) return;
    if (idle_cnt != 16'hFFFF) idle_cnt = idle_cnt + 16'd1;
    gap = (cfg.gap_ticks == 16'd0) ? 16'd1 : cfg.gap_ticks;
    if (idle_cnt < gap) return;
    v.status = judge_frame();
    v.address = address;
    v.func_code = func_code;
    v.body_bytes = body_cnt;
    v.drops = drops;
    due.push_back(v);
    close_frame();
  endfunction

  function void field_check(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_verdict(logic [63:0] d);
    frame_verdict_t v;
    if (due.size() == 0) begin
      $error("result item with nothing pending: %h", d);
      errors++;
      return;
    end
    v = due.pop_front();
    field_check("status", v.status, d[2:0]);
    field_check("frame_address", v.address, d[10:3]);
    field_check("function_code", v.func_code, d[18:11]);
    field_check("byte_count", v.body_bytes, d[28:19]);
    field_check("dropped_frames", v.drops, d[60:29]);
  endfunction
endclass

module tb;
  localparam int unsigned CYCLE_LIMIT  = 60000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned PHASE_ITEMS  = 55;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;

  frame_verdict_tracker sb;
  bit          calm;
  bit          rx_hold;
  int unsigned fed;
  int unsigned cycles;

  modbus_rtu_frame_checker_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL modbus_rtu_frame_checker_top");
        $finish;
      end
    end
  end

  // result side: random backpressure, or one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_verdict(m_tdata);
  end

  // called at a falling edge, returns at a falling edge
  task automatic feed(input logic act, input logic [7:0] b);
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(act, b);
    fed++;
    @(negedge clk);
  endtask

  task automatic wait_verdicts();
    if (sb.pending() != 0) begin
      s_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic apply_cfg(input logic [15:0] gap, input logic [7:0] station,
                           input logic master, input logic rate_en,
                           input logic [15:0] max_frames, input logic [23:0] window);
    wait_verdicts();
    s_tvalid <= 1'b0;
    // a closing tick may still be in flight with no result behind it
    repeat (6) @(negedge clk);
    write_reg(REG_GAP_TICKS, gap);
    write_reg(REG_STATION, station);
    write_reg(REG_MASTER_MODE, master);
    write_reg(REG_RATE_EN, rate_en);
    write_reg(REG_MAX_FRAMES, max_frames);
    write_reg(REG_WINDOW, window);
  endtask

  // address byte, body_len bytes after it (last two = CRC when body_len >= 2),
  // then enough ticks to close the frame
  task automatic send_frame(input logic [7:0] addr, input int body_len, input bit good_crc,
                            input bit mid_ticks, input int fill);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    int          gap;
    int          last;
    bytes.push_back(addr);
    for (int k = 0; k < body_len; k++) begin
      bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
    end
    if (body_len >= 2) begin
      last = bytes.size() - 1;
      crc = CRC_INIT;
      for (int k = 0; k < last - 1; k++) crc = crc16_byte(crc, bytes[k]);
      bytes[last - 1] = crc[7:0];
      bytes[last] = crc[15:8];
      if (!good_crc) bytes[last - $urandom_range(1)] ^= 8'h01 << $urandom_range(7);
    end
    gap = (sb.cfg.gap_ticks == 16'd0) ? 1 : sb.cfg.gap_ticks;
    foreach (bytes[k]) begin
      feed(ACT_BYTE, bytes[k]);
      // short silences inside the frame must not close it
      if (mid_ticks && gap > 1 && $urandom_range(5) == 0) begin
        repeat ($urandom_range(1, gap - 1)) feed(ACT_TICK, 8'($urandom_range(255)));
      end
    end
    repeat (gap + $urandom_range(2)) feed(ACT_TICK, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned phase;
    int unsigned rand_start;
    int unsigned phase_start;
    int unsigned r;
    int          len;
    logic [7:0]  addr;
    logic [7:0]  station;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = 8'h00;
    cfg_we = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 24'd0;
    calm = 1'b0;
    rx_hold = 1'b0;
    fed = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings apart from a short gap: station 1, slave, no rate limit
    write_reg(REG_GAP_TICKS, 24'd2);
    send_frame(8'd1, 6, 1'b1, 1'b0, -1);

    // zero gap behaves as one tick
    apply_cfg(16'd0, 8'd247, 1'b0, 1'b0, 16'd100, 24'd1000000);
    send_frame(8'd247, 5, 1'b1, 1'b0, 8'h00);
    send_frame(8'd0, 3, 1'b1, 1'b0, -1);
    send_frame(8'hFF, 4, 1'b1, 1'b0, 8'hFF);
    send_frame(8'd247, 0, 1'b1, 1'b0, -1);
    send_frame(8'd247, 1, 1'b1, 1'b0, -1);
    send_frame(8'd247, 2, 1'b1, 1'b0, -1);
    send_frame(8'd247, 8, 1'b0, 1'b0, -1);
    send_frame(8'd247, MAX_BODY_BYTES + 1, 1'b1, 1'b0, -1);
    // body counter saturates
    send_frame(8'd247, 1030, 1'b1, 1'b0, -1);

    // master with no responder set: everything past the length checks misses
    apply_cfg(16'd1, 8'd0, 1'b1, 1'b0, 16'd100, 24'd1000000);
    send_frame(8'd0, 4, 1'b1, 1'b0, -1);
    send_frame(8'd0, 2, 1'b1, 1'b0, -1);
    apply_cfg(16'd2, 8'd17, 1'b1, 1'b0, 16'd100, 24'd1000000);
    send_frame(8'd17, 6, 1'b1, 1'b1, -1);
    send_frame(8'd0, 6, 1'b1, 1'b1, -1);

    // rate limiting
    apply_cfg(16'd2, 8'd1, 1'b0, 1'b1, 16'd0, 24'hFFFFFF);
    send_frame(8'd1, 5, 1'b1, 1'b0, -1);
    send_frame(8'd1, 1, 1'b1, 1'b0, -1);
    // window of zero restarts at every frame
    apply_cfg(16'd2, 8'd1, 1'b0, 1'b1, 16'd2, 24'd0);
    repeat (3) send_frame(8'd1, 5, 1'b1, 1'b0, -1);
    apply_cfg(16'd3, 8'd1, 1'b0, 1'b1, 16'd1, 24'd1);
    repeat (2) send_frame(8'd1, 4, 1'b1, 1'b1, -1);
    apply_cfg(16'd3, 8'd1, 1'b0, 1'b1, 16'hFFFF, 24'hFFFFFF);
    repeat (2) send_frame(8'd1, 7, 1'b1, 1'b1, -1);

    rand_start = fed;
    phase = 0;
    while (fed - rand_start < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      station = (r < 10) ? 8'd0 : (r < 20) ? 8'd247 : 8'($urandom_range(1, 246));
      if (phase == 2) begin
        // short gap and a stalled receiver: results pile up and input backs off
        apply_cfg(16'd1, station, 1'b0, 1'b0, 16'd100, 24'd1000);
        rx_hold = 1'b1;
      end else begin
        apply_cfg(16'($urandom_range(1, 6)), station, 1'($urandom_range(1)),
                  $urandom_range(99) < 40,
                  ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(4)),
                  ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom_range(1, 300)));
      end
      calm = (phase == 1);
      phase_start = fed;
      while (fed - phase_start < PHASE_ITEMS && fed - rand_start < RANDOM_ITEMS) begin
        r = $urandom_range(99);
        if (r < 2) len = $urandom_range(505, 520);
        else if (r < 5) len = $urandom_range(250, 260);
        else if (r < 15) len = $urandom_range(2);
        else len = $urandom_range(3, 16);
        r = $urandom_range(99);
        if (r < 60) addr = sb.cfg.station_address;
        else if (r < 75) addr = 8'd0;
        else addr = 8'($urandom_range(255));
        send_frame(addr, len, $urandom_range(99) < 85, $urandom_range(99) < 30, -1);
        if ($urandom_range(19) == 0) wait_verdicts();
      end
      calm = 1'b0;
      phase++;
    end

    wait_verdicts();
    s_tvalid <= 1'b0;
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS modbus_rtu_frame_checker_top");
    end else begin
      $display("FAIL modbus_rtu_frame_checker_top");
    end
    $finish;
  end
endmodule
